FILE: hdl/clbc_pkg.sv
// clbc_pkg: shared types and constants for the card number check block
// used by clbc_ctrl, clbc_dp and card_number_luhn_brand_check; no dependencies
`timescale 1ns / 1ps

package clbc_pkg;

  // input number width and decimal digit storage
  localparam int IN_W       = 63;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DIG_W      = 5;
  localparam int CTR_W      = $clog2(IN_W);

  // default and bus widths
  localparam int DEF_MAX_DIGITS = 19;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 8;

  // brand codes
  localparam logic [1:0] BRAND_NONE = 2'd0;
  localparam logic [1:0] BRAND_AX   = 2'd1;
  localparam logic [1:0] BRAND_VS   = 2'd2;
  localparam logic [1:0] BRAND_MC   = 2'd3;

  // lengths used by the brand rules
  localparam logic [DIG_W-1:0] LEN_13 = DIG_W'(13);
  localparam logic [DIG_W-1:0] LEN_15 = DIG_W'(15);
  localparam logic [DIG_W-1:0] LEN_16 = DIG_W'(16);

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             conv;
    logic             scan;
    logic [DIG_W-1:0] idx;
    logic             out_load;
  } clbc_cmd_t;

endpackage

FILE: hdl/clbc_dp.sv
// clbc_dp: datapath with shift-add-3 converter, digit scanner and Luhn accumulator
// depends on clbc_pkg; driven by clbc_ctrl through clbc_cmd_t
`timescale 1ns / 1ps

module clbc_dp #(
  parameter int MAX_DIGITS = clbc_pkg::DEF_MAX_DIGITS
) (
  input  logic                       clk,
  input  clbc_pkg::clbc_cmd_t        cmd,
  input  logic [clbc_pkg::IN_W-1:0]  card_number,
  output logic [1:0]                 brand,
  output logic                       luhn_ok,
  output logic [clbc_pkg::DIG_W-1:0] digit_count
);
  import clbc_pkg::*;

  localparam logic [DIG_W-1:0] MAX_IDX = DIG_W'(MAX_DIGITS);

  logic [IN_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [4:0]       acc_r, acc_nxt;
  logic [DIG_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [3:0]       prev_r, prev_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [3:0]       lo_r, lo_nxt;
  logic [1:0]       brand_r;
  logic             luhn_r;
  logic [DIG_W-1:0] count_r;

  logic [3:0] dgt;
  logic [4:0] dbl, term, sum;
  logic       luhn_c;
  logic [1:0] brand_c;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // luhn term of the digit under scan, odd places doubled
  always_comb begin
    dgt = bcd_r[3:0];
    dbl = cmd.idx[0] ? {dgt, 1'b0} : {1'b0, dgt};
    term = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
    sum = acc_r + term;
  end

  // next state of the working registers
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    prev_nxt = prev_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (cmd.load) begin
      bin_nxt  = card_number;
      bcd_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      prev_nxt = '0;
      hi_nxt   = '0;
      lo_nxt   = '0;
    end else if (cmd.conv) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[IN_W-1]};
      bin_nxt = {bin_r[IN_W-2:0], 1'b0};
    end else if (cmd.scan) begin
      bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
      if (cmd.idx < MAX_IDX) begin
        acc_nxt  = (sum >= 5'd10) ? sum - 5'd10 : sum;
        prev_nxt = dgt;
        if (dgt != 4'd0) begin
          cnt_nxt = cmd.idx + DIG_W'(1);
          hi_nxt  = dgt;
          lo_nxt  = prev_r;
        end
      end else if (dgt != 4'd0) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // check result and brand rules
  always_comb begin
    luhn_c  = !ovf_r && (acc_r == 5'd0);
    brand_c = BRAND_NONE;
    if (luhn_c) begin
      if (cnt_r == LEN_15 && hi_r == 4'd3 && (lo_r == 4'd4 || lo_r == 4'd7)) begin
        brand_c = BRAND_AX;
      end else if ((cnt_r == LEN_16 || cnt_r == LEN_13) && hi_r == 4'd4) begin
        brand_c = BRAND_VS;
      end else if (cnt_r == LEN_16 && hi_r == 4'd5 && lo_r >= 4'd1 && lo_r <= 4'd5) begin
        brand_c = BRAND_MC;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    ovf_r  <= ovf_nxt;
    prev_r <= prev_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  // result register, loaded once per request; count saturates past the digit limit
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      brand_r <= brand_c;
      luhn_r  <= luhn_c;
      count_r <= ovf_r ? MAX_IDX : cnt_r;
    end
  end

  assign brand       = brand_r;
  assign luhn_ok     = luhn_r;
  assign digit_count = count_r;

endmodule

FILE: hdl/clbc_ctrl.sv
// clbc_ctrl: sequencer for conversion, digit scan and result hand-off
// depends on clbc_pkg; commands clbc_dp through clbc_cmd_t
`timescale 1ns / 1ps

module clbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output clbc_pkg::clbc_cmd_t cmd
);
  import clbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam logic [CTR_W-1:0] CONV_LAST = CTR_W'(IN_W - 1);
  localparam logic [CTR_W-1:0] SCAN_LAST = CTR_W'(BCD_DIGITS - 1);

  state_t           state_r, state_nxt;
  logic [CTR_W-1:0] ctr_r, ctr_nxt;
  logic             ovalid_r, ovalid_nxt;

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    cmd       = '0;
    cmd.idx   = ctr_r[DIG_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          ctr_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (ctr_r == CONV_LAST) begin
          ctr_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          ctr_nxt = ctr_r + CTR_W'(1);
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (ctr_r == SCAN_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          ctr_nxt = ctr_r + CTR_W'(1);
        end
      end
      ST_FINISH: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ctr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ctr_r    <= ctr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

FILE: hdl/card_number_luhn_brand_check.sv
// card_number_luhn_brand_check: top level of the card number check block
// depends on clbc_pkg, clbc_ctrl and clbc_dp
//
//   channel | direction | payload
//   in_     | request   | card_number
//   out_    | result    | brand, luhn_ok, digit_count
//
// each request runs through the accept step, 63 shift-add-3 steps (one per input
// bit), 19 digit scan steps for count and Luhn sum, one hand-off into the output register
// the result becomes valid at the edge that loads the output register
// the next request is taken once the result sits in the output register
// a stalled result holds the sequencer in its final step until taken
// rst_n is synchronous and active low; it clears the sequencer and valid flag
`timescale 1ns / 1ps

module card_number_luhn_brand_check #(
  parameter int MAX_DIGITS = clbc_pkg::DEF_MAX_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [clbc_pkg::IN_TDATA_W-1:0]  in_tdata,   // card_number[62:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [clbc_pkg::OUT_TDATA_W-1:0] out_tdata   // brand[1:0], luhn_ok[2], digit_count[7:3]
);
  import clbc_pkg::*;

  clbc_cmd_t        cmd;
  logic [1:0]       brand;
  logic             luhn_ok;
  logic [DIG_W-1:0] digit_count;

  // sequencer
  clbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // conversion and check datapath
  clbc_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .card_number (in_tdata[IN_W-1:0]),
    .brand       (brand),
    .luhn_ok     (luhn_ok),
    .digit_count (digit_count)
  );

  // result packing
  assign out_tdata = {digit_count, luhn_ok, brand};

endmodule
